>>> rtl/core/xtbd_pkg.sv
// ----------------------------------------------------------------------------
// xtbd_pkg: shared types and constants of the XTEA block decryptor
// Word and word-pair types, key register indexes, round constants and the
// mixing function used by every half-round stage.
// ----------------------------------------------------------------------------
package xtbd_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned KeyCount = 4;
  localparam int unsigned KeyIdxW  = 2;

  typedef logic [WordW-1:0] word_t;

  // Pair of words moving down the pipeline; a is the word feeding the mix,
  // b is the word being updated.
  typedef struct packed {
    word_t a;
    word_t b;
  } word_pair_t;

  typedef enum logic [KeyIdxW-1:0] {
    KEY_WORD0 = 2'd0,
    KEY_WORD1 = 2'd1,
    KEY_WORD2 = 2'd2,
    KEY_WORD3 = 2'd3
  } key_reg_e;

  localparam word_t Delta       = 32'h9E37_79B9;
  localparam word_t HeaderMagic = 32'hDEAD_BEEF;

  // Running sum after n remaining rounds: Delta * n mod 2^32.
  function automatic word_t round_sum(input int unsigned n);
    logic [2*WordW-1:0] prod;
    prod = {{WordW{1'b0}}, Delta} * (2*WordW)'(n);
    return prod[WordW-1:0];
  endfunction

  function automatic word_t mix_word(input word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

>>> rtl/core/xtea_block_decryptor.sv
// ----------------------------------------------------------------------------
// xtea_block_decryptor: pipelined reduced-round XTEA block decryptor
// 64-bit blocks, 128-bit configured key, one block per cycle when not stalled.
// ----------------------------------------------------------------------------
// Usage: load the four key words through the write port while the block is
// idle, then stream ciphertext blocks. Each accepted transaction runs through
// 2*ROUNDS register stages, one per half-round. One transaction is accepted
// every cycle while the output is not stalled; the throughput is set by the
// single half-round of logic between stage registers. Every stage holds its
// own valid bit, so bubbles close up and a stall on the output backs up stage
// by stage without dropping or repeating anything. magic_found_o flags a
// header block (second plaintext word equal to 0xDEADBEEF); blocks without it
// are still delivered.
// ----------------------------------------------------------------------------
module xtea_block_decryptor #(
  parameter int unsigned ROUNDS = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  // ciphertext input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] cipher_first_i,
  input  logic [31:0] cipher_second_i,
  // plaintext output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] plain_first_o,
  output logic [31:0] plain_second_o,
  output logic        magic_found_o
);

  localparam int unsigned NumStages = 2 * ROUNDS;

  // Key words; the user must write them only while the pipeline is empty, the block does not enforce it.
  xtbd_pkg::word_t key_q [xtbd_pkg::KeyCount];

  // Stage interconnect: index s is the input of stage s, index NumStages the
  // output of the last stage.
  logic                 stage_valid [NumStages+1];
  logic                 stage_ready [NumStages+1];
  xtbd_pkg::word_pair_t stage_pair  [NumStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < xtbd_pkg::KeyCount; k++) begin
        key_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (xtbd_pkg::key_reg_e'(cfg_addr_i))
        xtbd_pkg::KEY_WORD0: key_q[0] <= cfg_wdata_i;
        xtbd_pkg::KEY_WORD1: key_q[1] <= cfg_wdata_i;
        xtbd_pkg::KEY_WORD2: key_q[2] <= cfg_wdata_i;
        xtbd_pkg::KEY_WORD3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input side: a = left word, b = right word. The first half-round updates
  // the right word, so it enters as b.
  assign stage_valid[0]  = in_valid_i;
  assign stage_pair[0].a = cipher_first_i;
  assign stage_pair[0].b = cipher_second_i;
  assign in_stall_o      = !stage_ready[0];

  // The round sum is fixed per stage, so each stage gets its sum and its key
  // word select at elaboration.
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    // first half: sum before the decrement, key select from sum bits 12:11
    localparam xtbd_pkg::word_t SumHi = xtbd_pkg::round_sum(ROUNDS - r);
    // second half: sum after the decrement, key select from sum bits 1:0
    localparam xtbd_pkg::word_t SumLo = xtbd_pkg::round_sum(ROUNDS - r - 1);

    xtbd_half_round #(
      .SUM (SumHi)
    ) u_first_half (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[2*r]),
      .ready_o (stage_ready[2*r]),
      .pair_i  (stage_pair[2*r]),
      .key_i   (key_q[SumHi[12:11]]),
      .valid_o (stage_valid[2*r+1]),
      .ready_i (stage_ready[2*r+1]),
      .pair_o  (stage_pair[2*r+1])
    );

    xtbd_half_round #(
      .SUM (SumLo)
    ) u_second_half (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[2*r+1]),
      .ready_o (stage_ready[2*r+1]),
      .pair_i  (stage_pair[2*r+1]),
      .key_i   (key_q[SumLo[1:0]]),
      .valid_o (stage_valid[2*r+2]),
      .ready_i (stage_ready[2*r+2]),
      .pair_o  (stage_pair[2*r+2])
    );
  end

  // After an even number of swaps the pair is back in (left, right) order.
  assign stage_ready[NumStages] = !out_stall_i;
  assign out_valid_o            = stage_valid[NumStages];
  assign plain_first_o          = stage_pair[NumStages].a;
  assign plain_second_o         = stage_pair[NumStages].b;
  assign magic_found_o          = (stage_pair[NumStages].b == xtbd_pkg::HeaderMagic);

endmodule

>>> rtl/core/xtbd_half_round.sv
// ----------------------------------------------------------------------------
// xtbd_half_round: one registered XTEA decryption half-round
// Updates b by subtracting mix(a) ^ (SUM + key), then swaps the pair so the
// next stage sees the fresh word as its mix input. Valid/ready handshake.
// ----------------------------------------------------------------------------
module xtbd_half_round #(
  parameter logic [31:0] SUM = 32'h0000_0000
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  xtbd_pkg::word_pair_t pair_i,
  input  xtbd_pkg::word_t      key_i,
  output logic                valid_o,
  input  logic                ready_i,
  output xtbd_pkg::word_pair_t pair_o
);

  logic                 valid_q;
  xtbd_pkg::word_pair_t pair_q, pair_d;
  xtbd_pkg::word_t      round_key;

  assign ready_o   = !valid_q || ready_i;
  assign round_key = SUM + key_i;

  always_comb begin
    pair_d.a = pair_i.b - (xtbd_pkg::mix_word(pair_i.a) ^ round_key);
    pair_d.b = pair_i.a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pair_q <= pair_d;
    end
  end

  assign valid_o = valid_q;
  assign pair_o  = pair_q;

endmodule

>>> rtl/core/xtbd_checker.sv
// ----------------------------------------------------------------------------
// xtbd_checker: port-level checks for the XTEA block decryptor
// Output channel holding rules, header flag consistency and reset behavior.
// ----------------------------------------------------------------------------
module xtbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] plain_first_o,
  input logic [31:0] plain_second_o,
  input logic        magic_found_o
);

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(plain_first_o) && $stable(plain_second_o) && $stable(magic_found_o))
    else $error("output payload changed while stalled");

  a_magic_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (magic_found_o == (plain_second_o == 32'hDEAD_BEEF)))
    else $error("header flag disagrees with second plaintext word");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind xtea_block_decryptor xtbd_checker u_xtbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .plain_first_o  (plain_first_o),
  .plain_second_o (plain_second_o),
  .magic_found_o  (magic_found_o)
);
